// ===== rtl/srpq_pkg.sv =====
// Shared constants, codes and types for the sorted ring priority queue.
package srpq_pkg;

  localparam int DEPTH  = 16;
  localparam int PRIO_W = 8;
  localparam int DATA_W = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CFG_W  = 5;
  localparam int STAT_W = 2;

  localparam int IN_TDATA_W  = ((PRIO_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((PRIO_W + DATA_W + CNT_W + 7) / 8) * 8;

  typedef enum logic {
    REQ_ADD    = 1'b0,
    REQ_REMOVE = 1'b1
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_COMMIT = 1'b1
  } state_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] info;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic commit;
    logic norm;
  } cmd_t;

  typedef struct packed {
    logic norm_busy;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/srpq_ctrl.sv =====
// Controller state machine that sequences capture, commit and head normalization.
module srpq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  srpq_pkg::sts_t   sts,
  output srpq_pkg::cmd_t   cmd
);

  srpq_pkg::state_t state_r;
  srpq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srpq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srpq_pkg::ST_IDLE: begin
        if (in_tvalid && !sts.norm_busy) begin
          state_nxt = srpq_pkg::ST_COMMIT;
        end
      end
      srpq_pkg::ST_COMMIT: begin
        if (sts.out_free) begin
          state_nxt = srpq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = srpq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    cmd.norm    = 1'b0;
    unique case (state_r)
      srpq_pkg::ST_IDLE: begin
        in_tready   = !sts.norm_busy;
        cmd.capture = in_tvalid && !sts.norm_busy;
        cmd.norm    = sts.norm_busy;
      end
      srpq_pkg::ST_COMMIT: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/srpq_datapath.sv =====
// Datapath holding the entry ring, pointers, capacity and the result register.
module srpq_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [srpq_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [srpq_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic [srpq_pkg::STAT_W-1:0]           out_tuser,
  input  logic                                  cfg_we,
  input  logic [srpq_pkg::CFG_W-1:0]            cfg_wdata,
  input  srpq_pkg::cmd_t                        cmd,
  output srpq_pkg::sts_t                        sts
);

  localparam int DEPTH  = srpq_pkg::DEPTH;
  localparam int IDX_W  = srpq_pkg::IDX_W;
  localparam int CNT_W  = srpq_pkg::CNT_W;
  localparam int PRIO_W = srpq_pkg::PRIO_W;
  localparam int DATA_W = srpq_pkg::DATA_W;

  srpq_pkg::entry_t   store_r [DEPTH];
  logic [IDX_W-1:0]   lidx_r  [DEPTH];
  logic [IDX_W-1:0]   lidx_nxt[DEPTH];
  logic [DEPTH-1:0]   g_r;
  logic [DEPTH-1:0]   g_nxt;

  logic [IDX_W-1:0]   head_r;
  logic [IDX_W-1:0]   head_raw_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   cap_r;
  logic [CNT_W-1:0]   cap_nxt;

  srpq_pkg::req_t     req_r;
  srpq_pkg::entry_t   new_r;
  srpq_pkg::entry_t   in_entry;

  logic                          out_valid_r;
  srpq_pkg::status_t             out_status_r;
  srpq_pkg::entry_t              out_entry_r;
  logic [CNT_W-1:0]              out_count_r;

  logic [DEPTH:0]     s_vec;
  srpq_pkg::entry_t   slot_nxt [DEPTH];
  logic [DEPTH-1:0]   slot_we;
  srpq_pkg::entry_t   wrap_prev;
  logic [IDX_W-1:0]   cap_last;

  logic               add_ok;
  logic               rem_ok;
  srpq_pkg::status_t  status_nxt;
  logic [CNT_W-1:0]   count_nxt;
  logic [IDX_W-1:0]   head_nxt;
  logic [CNT_W-1:0]   count_dec;
  logic [CNT_W-1:0]   head_inc;

  assign in_entry.prio = in_tdata[PRIO_W-1:0];
  assign in_entry.info = in_tdata[PRIO_W+DATA_W-1:PRIO_W];

  // Logical position of every slot relative to the head, and which live
  // entries hold a priority at least that of the incoming one.
  always_comb begin
    logic [IDX_W:0] diff;
    logic [CNT_W:0] wrapped;
    g_nxt = '0;
    for (int s = 0; s < DEPTH; s++) begin
      diff    = (IDX_W+1)'(s) - {1'b0, head_r};
      wrapped = diff[IDX_W] ? ((CNT_W+1)'(diff) + {1'b0, cap_r})
                            : (CNT_W+1)'(diff);
      lidx_nxt[s] = wrapped[IDX_W-1:0];
      if ((CNT_W'(s) < cap_r) && ({1'b0, lidx_nxt[s]} < (IDX_W+1)'(count_r)) &&
          (store_r[s].prio >= in_entry.prio)) begin
        g_nxt[lidx_nxt[s]] = 1'b1;
      end
    end
  end

  // Positions from the insertion point up to the tail move one step back.
  always_comb begin
    logic acc;
    acc   = 1'b0;
    s_vec = '0;
    for (int j = DEPTH; j >= 0; j--) begin
      if (j < DEPTH) begin
        acc = acc | g_r[j];
      end
      s_vec[j] = ((CNT_W+1)'(j) <= {1'b0, count_r}) && !acc;
    end
  end

  assign cap_last  = IDX_W'(cap_r - CNT_W'(1));
  assign wrap_prev = store_r[cap_last];

  always_comb begin
    for (int s = 0; s < DEPTH; s++) begin
      slot_we[s]  = (CNT_W'(s) < cap_r) && s_vec[lidx_r[s]];
      if ((lidx_r[s] == '0) || !s_vec[lidx_r[s] - IDX_W'(1)]) begin
        slot_nxt[s] = new_r;
      end else if (s == 0) begin
        slot_nxt[s] = wrap_prev;
      end else begin
        slot_nxt[s] = store_r[(s == 0) ? 0 : s - 1];
      end
    end
  end

  assign add_ok    = (req_r == srpq_pkg::REQ_ADD) && (count_r < cap_r);
  assign rem_ok    = (req_r == srpq_pkg::REQ_REMOVE) && (count_r != '0);
  assign count_dec = count_r - CNT_W'(1);
  assign head_inc  = CNT_W'(head_r) + CNT_W'(1);

  always_comb begin
    count_nxt  = count_r;
    head_nxt   = head_raw_r;
    status_nxt = srpq_pkg::STAT_DONE;
    priority if (req_r == srpq_pkg::REQ_ADD) begin
      if (add_ok) begin
        count_nxt = count_r + CNT_W'(1);
        head_nxt  = head_r;
      end else begin
        status_nxt = srpq_pkg::STAT_FULL;
      end
    end else begin
      if (rem_ok) begin
        count_nxt = count_dec;
        if (count_dec == '0 || head_inc == cap_r) begin
          head_nxt = '0;
        end else begin
          head_nxt = head_inc[IDX_W-1:0];
        end
      end else begin
        status_nxt = srpq_pkg::STAT_EMPTY;
      end
    end
  end

  always_comb begin
    if (cfg_wdata == '0) begin
      cap_nxt = CNT_W'(1);
    end else if (int'(cfg_wdata) > DEPTH) begin
      cap_nxt = CNT_W'(DEPTH);
    end else begin
      cap_nxt = CNT_W'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= srpq_pkg::req_t'(in_tuser);
      new_r <= in_entry;
      g_r   <= g_nxt;
      for (int s = 0; s < DEPTH; s++) begin
        lidx_r[s] <= lidx_nxt[s];
      end
    end
    if (cmd.commit && add_ok) begin
      for (int s = 0; s < DEPTH; s++) begin
        if (slot_we[s]) begin
          store_r[s] <= slot_nxt[s];
        end
      end
    end
    if (cmd.commit) begin
      out_status_r <= status_nxt;
      out_count_r  <= count_nxt;
      if (rem_ok) begin
        out_entry_r <= store_r[head_r];
      end else begin
        out_entry_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      head_raw_r  <= '0;
      count_r     <= '0;
      cap_r       <= CNT_W'(DEPTH);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r  <= cap_nxt;
        head_r <= head_raw_r;
      end else if (cmd.norm) begin
        head_r <= IDX_W'(CNT_W'(head_r) - cap_r);
      end else if (cmd.commit && (add_ok || rem_ok)) begin
        head_r <= head_nxt;
      end
      if (cmd.commit) begin
        head_raw_r  <= head_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.norm_busy = CNT_W'(head_r) >= cap_r;
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = srpq_pkg::OUT_TDATA_W'({out_count_r, out_entry_r.info,
                                               out_entry_r.prio});

endmodule

// ===== rtl/sorted_ring_priority_queue.sv =====
// Top level of the sorted ring priority queue: controller plus datapath.
//
//   Channel  Direction  Transfer payload
//   in_*     slave      tuser: req_type; tdata: in_prio, in_info
//   out_*    master     tuser: status; tdata: out_prio, out_info, count
//   cfg_*    write      cfg_wdata: capacity, taken whenever cfg_we is high
//
// A request is first captured, with its priority compared against every held
// entry, and then committed, which shifts the ring and loads the result register.
// After a capacity write the head pointer is reduced by repeated subtraction,
// during which no request is taken.
// A result waiting on out_tready holds the next request in its commit cycle.
// Reset empties the queue and sets the capacity to sixteen.
module sorted_ring_priority_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [srpq_pkg::IN_TDATA_W-1:0]     in_tdata,   // in_prio, in_info
  input  logic                                in_tuser,   // req_type
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [srpq_pkg::OUT_TDATA_W-1:0]    out_tdata,  // out_prio, out_info, count
  output logic [srpq_pkg::STAT_W-1:0]         out_tuser,  // status
  input  logic                                cfg_we,
  input  logic [srpq_pkg::CFG_W-1:0]          cfg_wdata
);

  srpq_pkg::cmd_t cmd;
  srpq_pkg::sts_t sts;

  srpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  srpq_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the sorted ring priority queue: directed and random requests with a predictor.
`timescale 1ns / 100ps

module tb_top;

  localparam int RESET_CYCLES  = 10;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 400000;

  localparam int DEPTH       = srpq_pkg::DEPTH;
  localparam int PRIO_W      = srpq_pkg::PRIO_W;
  localparam int DATA_W      = srpq_pkg::DATA_W;
  localparam int CNT_W       = srpq_pkg::CNT_W;
  localparam int CFG_W       = srpq_pkg::CFG_W;
  localparam int STAT_W      = srpq_pkg::STAT_W;
  localparam int IN_TDATA_W  = srpq_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = srpq_pkg::OUT_TDATA_W;

  typedef struct {
    srpq_pkg::status_t status;
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] info;
    logic [CNT_W-1:0]  count;
  } queue_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // in_prio, in_info
  logic                   in_tuser = 1'b0; // req_type
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // out_prio, out_info, count
  logic [STAT_W-1:0]      out_tuser;       // status
  logic                   cfg_we = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  srpq_pkg::entry_t pq_slot [DEPTH];
  int unsigned      pq_head;
  int unsigned      pq_count;
  int unsigned      pq_capacity;
  queue_result_t    pending_results[$];
  int unsigned      mismatches = 0;
  int unsigned      cycles = 0;
  bit               no_idle = 1'b0;
  int unsigned      hold_req = 0;
  int unsigned      hold_seen = 0;
  int unsigned      hold_left = 0;

  sorted_ring_priority_queue i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk) begin
    queue_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no request outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          mismatches++;
        end
        if (out_tdata[PRIO_W-1:0] !== want.prio) begin
          $error("out_prio: expected %0d, got %0d", want.prio, out_tdata[PRIO_W-1:0]);
          mismatches++;
        end
        if (out_tdata[PRIO_W+DATA_W-1:PRIO_W] !== want.info) begin
          $error("out_info: expected %0d, got %0d", want.info,
                 out_tdata[PRIO_W+DATA_W-1:PRIO_W]);
          mismatches++;
        end
        if (out_tdata[PRIO_W+DATA_W+CNT_W-1:PRIO_W+DATA_W] !== want.count) begin
          $error("count: expected %0d, got %0d", want.count,
                 out_tdata[PRIO_W+DATA_W+CNT_W-1:PRIO_W+DATA_W]);
          mismatches++;
        end
        if (out_tdata[OUT_TDATA_W-1:PRIO_W+DATA_W+CNT_W] !== '0) begin
          $error("tdata padding: expected 0, got %0h",
                 out_tdata[OUT_TDATA_W-1:PRIO_W+DATA_W+CNT_W]);
          mismatches++;
        end
      end
    end
  end

  function automatic queue_result_t predict_queue_op(srpq_pkg::req_t req,
                                                     logic [PRIO_W-1:0] prio,
                                                     logic [DATA_W-1:0] info);
    queue_result_t    res;
    int unsigned      cap;
    int unsigned      hd;
    int unsigned      pos;
    int unsigned      prv;
    int unsigned      steps;
    srpq_pkg::entry_t tmp;
    cap = (pq_capacity == 0) ? 1 : (pq_capacity > DEPTH) ? DEPTH : pq_capacity;
    hd  = pq_head % cap;
    res.status = srpq_pkg::STAT_DONE;
    res.prio   = '0;
    res.info   = '0;
    if (req == srpq_pkg::REQ_ADD) begin
      if (pq_count >= cap) begin
        res.status = srpq_pkg::STAT_FULL;
      end else begin
        pos   = (hd + pq_count) % cap;
        steps = pq_count;
        pq_slot[pos].prio = prio;
        pq_slot[pos].info = info;
        while (steps > 0) begin
          prv = (pos + cap - 1) % cap;
          if (pq_slot[pos].prio <= pq_slot[prv].prio) break;
          tmp          = pq_slot[pos];
          pq_slot[pos] = pq_slot[prv];
          pq_slot[prv] = tmp;
          pos = prv;
          steps--;
        end
        pq_head = hd;
        pq_count++;
      end
    end else begin
      if (pq_count == 0) begin
        res.status = srpq_pkg::STAT_EMPTY;
      end else begin
        res.prio = pq_slot[hd].prio;
        res.info = pq_slot[hd].info;
        pq_count--;
        pq_head = (pq_count == 0) ? 0 : (hd + 1) % cap;
      end
    end
    res.count = CNT_W'(pq_count);
    return res;
  endfunction

  function automatic logic [PRIO_W-1:0] pick_prio();
    case ($urandom_range(3))
      0: return PRIO_W'($urandom_range(3));
      1: return ($urandom_range(1) != 0) ? {PRIO_W{1'b1}} : {PRIO_W{1'b0}};
      default: return PRIO_W'($urandom);
    endcase
  endfunction

  task automatic send_request(srpq_pkg::req_t req, logic [PRIO_W-1:0] prio,
                              logic [DATA_W-1:0] info);
    if (!no_idle && $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 12) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {info, prio};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_queue_op(req, prio, info));
  endtask

  task automatic send_random(int unsigned add_pct);
    srpq_pkg::req_t req;
    req = ($urandom_range(99) < add_pct) ? srpq_pkg::REQ_ADD : srpq_pkg::REQ_REMOVE;
    send_request(req, pick_prio(), DATA_W'($urandom));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CFG_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    pq_capacity = 32'(value);
  endtask

  task automatic test_fill_and_order();
    logic [PRIO_W-1:0] prios [8];
    prios = '{8'h00, 8'hFF, 8'h80, 8'h80, 8'h00, 8'hFF, 8'h01, 8'hFE};
    send_request(srpq_pkg::REQ_REMOVE, '0, '0);
    send_request(srpq_pkg::REQ_ADD, prios[0], 16'h0000);
    send_request(srpq_pkg::REQ_ADD, prios[1], 16'hFFFF);
    for (int i = 2; i < 8; i++) send_request(srpq_pkg::REQ_ADD, prios[i], DATA_W'(i));
    for (int i = 8; i < DEPTH; i++) begin
      send_request(srpq_pkg::REQ_ADD, pick_prio(), DATA_W'($urandom));
    end
    send_request(srpq_pkg::REQ_ADD, 8'h55, 16'hAAAA);
    for (int i = 0; i < 6; i++) begin
      send_request(srpq_pkg::REQ_REMOVE, PRIO_W'($urandom), DATA_W'($urandom));
    end
  endtask

  task automatic test_capacity_limits();
    logic [CFG_W-1:0] caps [6];
    caps = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd16};
    foreach (caps[i]) begin
      set_capacity(caps[i]);
      for (int n = 0; n < 14; n++) send_random(50);
    end
  endtask

  task automatic test_random_traffic();
    int unsigned add_pct;
    int unsigned pick;
    for (int phase = 0; phase < 30; phase++) begin
      no_idle = (phase < 3);
      pick = $urandom_range(9);
      case (pick)
        0: set_capacity(5'd0);
        1: set_capacity(5'd31);
        2: set_capacity(5'd1);
        3, 4: set_capacity(5'd16);
        5: set_capacity(CFG_W'($urandom_range(31)));
        default: set_capacity(CFG_W'($urandom_range(DEPTH, 2)));
      endcase
      case (phase % 3)
        0: add_pct = 70;
        1: add_pct = 30;
        default: add_pct = 50;
      endcase
      for (int n = 0; n < 50; n++) send_random(add_pct);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    set_capacity(5'd16);
    hold_req++;
    for (int n = 0; n < 40; n++) send_random(65);
    wait_drained();
    for (int n = 0; n < 30; n++) send_random(40);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    pq_head     = 0;
    pq_count    = 0;
    pq_capacity = DEPTH;
    foreach (pq_slot[i]) pq_slot[i] = '0;
    @(posedge clk);
    test_fill_and_order();
    test_capacity_limits();
    test_random_traffic();
    test_backpressure();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/srpq_pkg.sv
rtl/srpq_ctrl.sv
rtl/srpq_datapath.sv
rtl/sorted_ring_priority_queue.sv
tb/tb_top.sv
